[src/isb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isb_pkg
// Shared types and constants of the integer batch sorter.
// ----------------------------------------------------------------------------
package isb_pkg;

  localparam int unsigned ValueW          = 32;
  localparam int unsigned DefaultCapacity = 64;

  // Contents of one cell of the sorting chain.
  typedef struct packed {
    logic                     valid;
    logic signed [ValueW-1:0] value;
  } cell_data_t;

  // Chain-wide command, the same for every cell.
  typedef struct packed {
    logic insert;  // place a new item in sorted position
    logic shift;   // move every cell one place toward the output
  } cell_ctrl_t;

endpackage

[src/isb_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isb_cell
// One cell of the insertion sorting chain: holds one value and trades it
// with its neighbors.
// ----------------------------------------------------------------------------
module isb_cell (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  isb_pkg::cell_ctrl_t                      ctrl_i,
  input  logic signed [isb_pkg::ValueW-1:0]        ins_value_i,
  input  logic                                     prev_gt_i,
  input  isb_pkg::cell_data_t                      prev_data_i,
  input  isb_pkg::cell_data_t                      next_data_i,
  output isb_pkg::cell_data_t                      data_o,
  output logic                                     gt_o
);

  logic                               valid_q, valid_d;
  logic signed [isb_pkg::ValueW-1:0]  value_q, value_d;

  // An empty cell counts as greater than any value, and equal values stay
  // ahead of the new one, which keeps the sort stable.
  assign gt_o = !valid_q || (value_q > ins_value_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (ctrl_i.shift) begin
      valid_d = next_data_i.valid;
      value_d = next_data_i.value;
    end else if (ctrl_i.insert && gt_o) begin
      if (prev_gt_i) begin
        valid_d = prev_data_i.valid;
        value_d = prev_data_i.value;
      end else begin
        valid_d = 1'b1;
        value_d = ins_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign data_o = '{valid: valid_q, value: value_q};

endmodule

[src/integer_batch_sorter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_batch_sorter
// Stable ascending sort of batches of signed 32-bit integers.
// ----------------------------------------------------------------------------
// A batch of N items loads at one item per cycle into a chain of CAPACITY
// cells, each item dropping straight into its sorted place. The batch closes
// on an item with is_last_i set or on the item that fills the chain. The
// chain then shifts toward the output, giving one sorted value per cycle
// from the first cell while out_stall_i is low. While a batch drains,
// in_stall_o is high.
// ----------------------------------------------------------------------------
module integer_batch_sorter #(
  parameter int unsigned CAPACITY = isb_pkg::DefaultCapacity
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [isb_pkg::ValueW-1:0]  value_i,
  input  logic                               is_last_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [isb_pkg::ValueW-1:0]  value_res_o,
  output logic                               is_last_res_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam logic [CountW-1:0] CountFull = CountW'(CAPACITY);
  localparam logic [CountW-1:0] CountOne  = CountW'(1);

  logic [CountW-1:0]    count_q, count_d;
  logic                 drain_q, drain_d;
  logic                 in_accept, out_accept;
  isb_pkg::cell_ctrl_t  ctrl;

  isb_pkg::cell_data_t  data   [CAPACITY];
  logic                 gt     [CAPACITY];

  assign in_stall_o  = drain_q;
  assign in_accept   = in_valid_i && !drain_q;
  assign out_valid_o = drain_q;
  assign out_accept  = drain_q && !out_stall_i;

  assign ctrl = '{insert: in_accept, shift: out_accept};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    isb_pkg::cell_data_t prev_data, next_data;
    logic                prev_gt;

    if (i == 0) begin : g_first
      assign prev_gt   = 1'b0;
      assign prev_data = '0;
    end else begin : g_mid
      assign prev_gt   = gt[i-1];
      assign prev_data = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_inner
      assign next_data = data[i+1];
    end

    isb_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .ins_value_i (value_i),
      .prev_gt_i   (prev_gt),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (data[i]),
      .gt_o        (gt[i])
    );
  end

  assign value_res_o   = data[0].value;
  assign is_last_res_o = (count_q == CountOne);

  always_comb begin
    count_d = count_q;
    drain_d = drain_q;
    if (in_accept) begin
      count_d = count_q + CountOne;
      if (is_last_i || (count_d == CountFull)) begin
        drain_d = 1'b1;
      end
    end else if (out_accept) begin
      count_d = count_q - CountOne;
      if (count_q == CountOne) begin
        drain_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drain_q <= 1'b0;
    end else begin
      count_q <= count_d;
      drain_q <= drain_d;
    end
  end

endmodule

[verif/integer_batch_sorter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_batch_sorter_tb
// Self-checking testbench for the integer batch sorter.
// ----------------------------------------------------------------------------
// Batches of signed integers are sent one item at a time. A stable insertion
// model builds the sorted batch for every accepted item and queues the results
// once the batch closes, either on is_last or when the store fills. A checker
// compares every accepted result against the oldest queued one. Both sides
// idle at random, and one phase holds the output off long enough for the
// block to fill up and stall its input.
// ----------------------------------------------------------------------------
module integer_batch_sorter_tb;

  localparam int unsigned Capacity = isb_pkg::DefaultCapacity;
  localparam int unsigned ValueW   = isb_pkg::ValueW;

  localparam logic signed [ValueW-1:0] MinValue = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] MaxValue = {1'b0, {(ValueW-1){1'b1}}};

  typedef logic signed [ValueW-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
  } sorted_result_t;

  logic   clk_i         = 1'b0;
  logic   rst_ni        = 1'b0;
  logic   in_valid_i    = 1'b0;
  logic   in_stall_o;
  value_t value_i       = '0;
  logic   is_last_i     = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i   = 1'b0;
  value_t value_res_o;
  logic   is_last_res_o;

  // Values of the batch still loading, kept in ascending order.
  value_t         open_batch_q[$];
  // Sorted values of closed batches that have not come out yet.
  sorted_result_t sorted_q[$];

  int unsigned mismatch_count = 0;
  bit          send_gaps_en   = 1'b0;
  bit          recv_gaps_en   = 1'b0;
  int unsigned hold_cycles    = 0;

  integer_batch_sorter #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .is_last_i    (is_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_res_o  (value_res_o),
    .is_last_res_o(is_last_res_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Stable insertion: a new value goes after every stored value not greater
  // than it. The batch closes on is_last or when the store is full.
  task automatic sort_accept(input value_t v, input logic last);
    int unsigned pos;
    pos = open_batch_q.size();
    while (pos > 0 && open_batch_q[pos-1] > v) pos--;
    open_batch_q.insert(pos, v);
    if (last || open_batch_q.size() == Capacity) begin
      foreach (open_batch_q[i]) begin
        sorted_q.push_back('{value: open_batch_q[i],
                             last:  (i == open_batch_q.size() - 1)});
      end
      open_batch_q.delete();
    end
  endtask

  // Offers one item and returns at the edge where it is taken. Valid stays
  // high afterwards so the next item can follow without a bubble.
  task automatic send_item(input value_t v, input logic last);
    int unsigned gap;
    if (send_gaps_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      is_last_i  <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    is_last_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sort_accept(v, last);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_sorted_out();
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Extremes and small values with many ties.
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0:       return MinValue;
      1:       return MaxValue;
      2, 3, 4: return value_t'($urandom_range(0, 15)) - 8;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Receiver side: random stalls, plus one long hold when asked for.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        out_stall_i <= 1'b0;
      end else if (recv_gaps_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    sorted_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_q.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("Unexpected result: value %0d last %0b", value_res_o, is_last_res_o);
        end
        mismatch_count++;
      end else begin
        want = sorted_q.pop_front();
        if (value_res_o !== want.value || is_last_res_o !== want.last) begin
          if (mismatch_count < 10) begin
            $display("Mismatch: expected value %0d last %0b, got value %0d last %0b",
                     want.value, want.last, value_res_o, is_last_res_o);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Single-item batches at the extremes of the value range.
  task automatic test_single_item_batches();
    send_item(MinValue, 1'b1);
    send_item(MaxValue, 1'b1);
    send_item(0, 1'b1);
    send_item(-1, 1'b1);
    send_item(1, 1'b1);
    drop_valid();
    wait_sorted_out();
  endtask

  // Ties, extremes and a batch that arrives in descending order.
  task automatic test_ties_and_order();
    value_t mixed[10] = '{5, -3, 5, MinValue, MaxValue, -3, 0, MaxValue, MinValue, 7};
    foreach (mixed[i]) send_item(mixed[i], i == 9);
    for (int i = 0; i < 6; i++) send_item(value_t'(100 - 37 * i), i == 5);
    drop_valid();
    wait_sorted_out();
  endtask

  // The output is held off while items keep coming, so the store fills,
  // closes without is_last and the input stalls until the hold ends.
  task automatic test_full_store_backpressure();
    hold_cycles = 400;
    for (int i = 0; i < Capacity; i++) send_item(pick_value(), 1'b0);
    for (int i = 0; i < 6; i++) send_item(pick_value(), i == 5);
    drop_valid();
    wait_sorted_out();
  endtask

  // Random batches, mostly short, now and then up to the full store, with
  // a stray is_last now and then.
  task automatic test_random_batches();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < 32) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, Capacity) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
        send_item(pick_value(), (i == len - 1) || ($urandom_range(0, 11) == 0));
      end
      sent += len;
      if ($urandom_range(0, 4) == 0) begin
        drop_valid();
        wait_sorted_out();
      end
    end
    drop_valid();
    wait_sorted_out();
  endtask

  // Back-to-back batches with no idling on either side.
  task automatic test_streaming();
    int unsigned len;
    for (int b = 0; b < 3; b++) begin
      len = $urandom_range(1, 20);
      for (int i = 0; i < len; i++) send_item(value_t'($urandom), i == len - 1);
    end
    drop_valid();
  endtask

  initial begin
    int unsigned guard;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gaps_en = 1'b1;
    recv_gaps_en = 1'b1;
    test_single_item_batches();
    test_ties_and_order();
    send_gaps_en = 1'b0;
    recv_gaps_en = 1'b0;
    test_full_store_backpressure();
    send_gaps_en = 1'b1;
    recv_gaps_en = 1'b1;
    test_random_batches();
    send_gaps_en = 1'b0;
    recv_gaps_en = 1'b0;
    repeat (12) @(posedge clk_i);
    test_streaming();

    guard = 0;
    while (sorted_q.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && sorted_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
